// ===== src/bi_pkg.sv =====
package bi_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ADDR_W    = 6;
    localparam int PC_W      = 7;
    localparam int DIV_W     = WORD_W + FRAC_W;
    localparam int CNT_W     = 6;
    localparam int OUT_CNT   = 11;
    localparam int OUT_IDX_W = 4;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RASTER  = 2'd1;
    localparam logic [1:0] CMD_SPATIAL = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [1:0] VTX_NONE = 2'd3;

    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_DEGEN   = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_OUT_BASE = 6'd40;
    localparam logic [ADDR_W-1:0] ADDR_OUT_LAST = 6'd50;

    localparam logic [PC_W-1:0] PC_LOAD   = 7'd0;
    localparam logic [PC_W-1:0] PC_RASTER = 7'd22;
    localparam logic [PC_W-1:0] PC_SPAT   = 7'd33;
    localparam logic [PC_W-1:0] PC_TAIL   = 7'd82;

    typedef struct packed {
        logic [1:0]               command;
        logic [1:0]               vertex_index;
        logic signed [WORD_W-1:0] coord_x;
        logic signed [WORD_W-1:0] coord_y;
        logic signed [WORD_W-1:0] coord_z;
        logic signed [WORD_W-1:0] tex_u;
        logic signed [WORD_W-1:0] tex_v;
        logic signed [WORD_W-1:0] norm_x;
        logic signed [WORD_W-1:0] norm_y;
        logic signed [WORD_W-1:0] norm_z;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] weight_first;
        logic signed [WORD_W-1:0] weight_second;
        logic signed [WORD_W-1:0] weight_third;
        logic [1:0]               status;
        logic signed [WORD_W-1:0] out_pos_x;
        logic signed [WORD_W-1:0] out_pos_y;
        logic signed [WORD_W-1:0] out_pos_z;
        logic signed [WORD_W-1:0] out_tex_u;
        logic signed [WORD_W-1:0] out_tex_v;
        logic signed [WORD_W-1:0] out_norm_x;
        logic signed [WORD_W-1:0] out_norm_y;
        logic signed [WORD_W-1:0] out_norm_z;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_LDV, OP_LDT, OP_ADD, OP_SUB, OP_ONESUB, OP_MUL, OP_DIV,
        OP_CHK, OP_JTAIL, OP_ENDL, OP_ENDQ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] d;
    } t_uop;

    typedef enum logic [2:0] {
        PH_IDLE, PH_READ, PH_EXEC, PH_MULW, PH_DIV
    } t_phase;

    typedef struct packed {
        logic   capture;
        t_phase phase;
        t_uop   uop;
        logic   publish;
        logic   pub_degen;
    } t_dp_cmd;

    typedef struct packed {
        logic opa_zero;
        logic div_done;
    } t_dp_stat;

    function automatic t_uop mk(t_op op, int a, int b, int d);
        t_uop u;
        u.op = op;
        u.a  = ADDR_W'(a);
        u.b  = ADDR_W'(b);
        u.d  = ADDR_W'(d);
        return u;
    endfunction

    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            7'd0:   u = mk(OP_LDV, 0, 0, 0);
            7'd1:   u = mk(OP_LDV, 1, 0, 0);
            7'd2:   u = mk(OP_LDV, 2, 0, 0);
            7'd3:   u = mk(OP_LDV, 3, 0, 0);
            7'd4:   u = mk(OP_LDV, 4, 0, 0);
            7'd5:   u = mk(OP_LDV, 5, 0, 0);
            7'd6:   u = mk(OP_LDV, 6, 0, 0);
            7'd7:   u = mk(OP_LDV, 7, 0, 0);
            7'd8:   u = mk(OP_SUB, 9, 17, 28);
            7'd9:   u = mk(OP_SUB, 16, 8, 29);
            7'd10:  u = mk(OP_SUB, 17, 1, 30);
            7'd11:  u = mk(OP_SUB, 0, 16, 31);
            7'd12:  u = mk(OP_SUB, 1, 17, 32);
            7'd13:  u = mk(OP_MUL, 28, 31, 33);
            7'd14:  u = mk(OP_MUL, 29, 32, 34);
            7'd15:  u = mk(OP_ADD, 33, 34, 35);
            7'd16:  u = mk(OP_CHK, 35, 0, 0);
            7'd17:  u = mk(OP_DIV, 28, 35, 24);
            7'd18:  u = mk(OP_DIV, 29, 35, 25);
            7'd19:  u = mk(OP_DIV, 30, 35, 26);
            7'd20:  u = mk(OP_DIV, 31, 35, 27);
            7'd21:  u = mk(OP_ENDL, 0, 0, 0);
            7'd22:  u = mk(OP_LDT, 0, 0, 52);
            7'd23:  u = mk(OP_LDT, 1, 0, 53);
            7'd24:  u = mk(OP_SUB, 52, 16, 28);
            7'd25:  u = mk(OP_SUB, 53, 17, 29);
            7'd26:  u = mk(OP_MUL, 28, 24, 30);
            7'd27:  u = mk(OP_MUL, 29, 25, 31);
            7'd28:  u = mk(OP_ADD, 30, 31, 40);
            7'd29:  u = mk(OP_MUL, 28, 26, 30);
            7'd30:  u = mk(OP_MUL, 29, 27, 31);
            7'd31:  u = mk(OP_ADD, 30, 31, 41);
            7'd32:  u = mk(OP_JTAIL, 0, 0, 0);
            7'd33:  u = mk(OP_LDT, 0, 0, 52);
            7'd34:  u = mk(OP_LDT, 1, 0, 53);
            7'd35:  u = mk(OP_LDT, 2, 0, 54);
            7'd36:  u = mk(OP_SUB, 0, 16, 28);
            7'd37:  u = mk(OP_SUB, 1, 17, 29);
            7'd38:  u = mk(OP_SUB, 2, 18, 30);
            7'd39:  u = mk(OP_SUB, 8, 16, 31);
            7'd40:  u = mk(OP_SUB, 9, 17, 32);
            7'd41:  u = mk(OP_SUB, 10, 18, 33);
            7'd42:  u = mk(OP_SUB, 52, 16, 34);
            7'd43:  u = mk(OP_SUB, 53, 17, 35);
            7'd44:  u = mk(OP_SUB, 54, 18, 36);
            7'd45:  u = mk(OP_MUL, 28, 28, 37);
            7'd46:  u = mk(OP_MUL, 29, 29, 38);
            7'd47:  u = mk(OP_ADD, 37, 38, 39);
            7'd48:  u = mk(OP_MUL, 30, 30, 38);
            7'd49:  u = mk(OP_ADD, 39, 38, 55);
            7'd50:  u = mk(OP_MUL, 28, 31, 37);
            7'd51:  u = mk(OP_MUL, 29, 32, 38);
            7'd52:  u = mk(OP_ADD, 37, 38, 39);
            7'd53:  u = mk(OP_MUL, 30, 33, 38);
            7'd54:  u = mk(OP_ADD, 39, 38, 56);
            7'd55:  u = mk(OP_MUL, 31, 31, 37);
            7'd56:  u = mk(OP_MUL, 32, 32, 38);
            7'd57:  u = mk(OP_ADD, 37, 38, 39);
            7'd58:  u = mk(OP_MUL, 33, 33, 38);
            7'd59:  u = mk(OP_ADD, 39, 38, 57);
            7'd60:  u = mk(OP_MUL, 34, 28, 37);
            7'd61:  u = mk(OP_MUL, 35, 29, 38);
            7'd62:  u = mk(OP_ADD, 37, 38, 39);
            7'd63:  u = mk(OP_MUL, 36, 30, 38);
            7'd64:  u = mk(OP_ADD, 39, 38, 58);
            7'd65:  u = mk(OP_MUL, 34, 31, 37);
            7'd66:  u = mk(OP_MUL, 35, 32, 38);
            7'd67:  u = mk(OP_ADD, 37, 38, 39);
            7'd68:  u = mk(OP_MUL, 36, 33, 38);
            7'd69:  u = mk(OP_ADD, 39, 38, 59);
            7'd70:  u = mk(OP_MUL, 55, 57, 37);
            7'd71:  u = mk(OP_MUL, 56, 56, 38);
            7'd72:  u = mk(OP_SUB, 37, 38, 60);
            7'd73:  u = mk(OP_CHK, 60, 0, 0);
            7'd74:  u = mk(OP_MUL, 57, 58, 37);
            7'd75:  u = mk(OP_MUL, 56, 59, 38);
            7'd76:  u = mk(OP_SUB, 37, 38, 61);
            7'd77:  u = mk(OP_MUL, 55, 59, 37);
            7'd78:  u = mk(OP_MUL, 56, 58, 38);
            7'd79:  u = mk(OP_SUB, 37, 38, 62);
            7'd80:  u = mk(OP_DIV, 61, 60, 40);
            7'd81:  u = mk(OP_DIV, 62, 60, 41);
            7'd82:  u = mk(OP_ONESUB, 40, 0, 32);
            7'd83:  u = mk(OP_SUB, 32, 41, 42);
            7'd84:  u = mk(OP_MUL, 40, 0, 30);
            7'd85:  u = mk(OP_MUL, 41, 8, 31);
            7'd86:  u = mk(OP_ADD, 30, 31, 32);
            7'd87:  u = mk(OP_MUL, 42, 16, 33);
            7'd88:  u = mk(OP_ADD, 32, 33, 43);
            7'd89:  u = mk(OP_MUL, 40, 1, 30);
            7'd90:  u = mk(OP_MUL, 41, 9, 31);
            7'd91:  u = mk(OP_ADD, 30, 31, 32);
            7'd92:  u = mk(OP_MUL, 42, 17, 33);
            7'd93:  u = mk(OP_ADD, 32, 33, 44);
            7'd94:  u = mk(OP_MUL, 40, 2, 30);
            7'd95:  u = mk(OP_MUL, 41, 10, 31);
            7'd96:  u = mk(OP_ADD, 30, 31, 32);
            7'd97:  u = mk(OP_MUL, 42, 18, 33);
            7'd98:  u = mk(OP_ADD, 32, 33, 45);
            7'd99:  u = mk(OP_MUL, 40, 3, 30);
            7'd100: u = mk(OP_MUL, 41, 11, 31);
            7'd101: u = mk(OP_ADD, 30, 31, 32);
            7'd102: u = mk(OP_MUL, 42, 19, 33);
            7'd103: u = mk(OP_ADD, 32, 33, 46);
            7'd104: u = mk(OP_MUL, 40, 4, 30);
            7'd105: u = mk(OP_MUL, 41, 12, 31);
            7'd106: u = mk(OP_ADD, 30, 31, 32);
            7'd107: u = mk(OP_MUL, 42, 20, 33);
            7'd108: u = mk(OP_ADD, 32, 33, 47);
            7'd109: u = mk(OP_MUL, 40, 5, 30);
            7'd110: u = mk(OP_MUL, 41, 13, 31);
            7'd111: u = mk(OP_ADD, 30, 31, 32);
            7'd112: u = mk(OP_MUL, 42, 21, 33);
            7'd113: u = mk(OP_ADD, 32, 33, 48);
            7'd114: u = mk(OP_MUL, 40, 6, 30);
            7'd115: u = mk(OP_MUL, 41, 14, 31);
            7'd116: u = mk(OP_ADD, 30, 31, 32);
            7'd117: u = mk(OP_MUL, 42, 22, 33);
            7'd118: u = mk(OP_ADD, 32, 33, 49);
            7'd119: u = mk(OP_MUL, 40, 7, 30);
            7'd120: u = mk(OP_MUL, 41, 15, 31);
            7'd121: u = mk(OP_ADD, 30, 31, 32);
            7'd122: u = mk(OP_MUL, 42, 23, 33);
            7'd123: u = mk(OP_ADD, 32, 33, 50);
            default: u = mk(OP_ENDQ, 0, 0, 0);
        endcase
        return u;
    endfunction

endpackage

// ===== src/bi_ctrl.sv =====
module bi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_command,
    input  logic [1:0]        i_vertex_index,
    input  bi_pkg::t_dp_stat  i_stat,
    output bi_pkg::t_dp_cmd   o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_MULW = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [bi_pkg::PC_W-1:0]   r_pc, n_pc;
    logic                      r_degen, n_degen;
    logic                      r_valid, n_valid;
    bi_pkg::t_uop              uop;

    assign uop     = bi_pkg::ucode(r_pc);
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_degen = r_degen;
        n_valid = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.phase     = bi_pkg::PH_IDLE;
        o_cmd.uop       = uop;
        o_cmd.publish   = 1'b0;
        o_cmd.pub_degen = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_command)
                        bi_pkg::CMD_LOAD: begin
                            if (i_vertex_index != bi_pkg::VTX_NONE) begin
                                n_pc    = bi_pkg::PC_LOAD;
                                n_state = S_READ;
                            end
                        end
                        bi_pkg::CMD_RASTER: begin
                            if (r_degen) begin
                                o_cmd.publish   = 1'b1;
                                o_cmd.pub_degen = 1'b1;
                                n_valid         = 1'b1;
                            end else begin
                                n_pc    = bi_pkg::PC_RASTER;
                                n_state = S_READ;
                            end
                        end
                        bi_pkg::CMD_SPATIAL: begin
                            n_pc    = bi_pkg::PC_SPAT;
                            n_state = S_READ;
                        end
                        bi_pkg::CMD_NONE: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.phase = bi_pkg::PH_READ;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.phase = bi_pkg::PH_EXEC;
                unique case (uop.op)
                    bi_pkg::OP_MUL: n_state = S_MULW;
                    bi_pkg::OP_DIV: n_state = S_DIV;
                    bi_pkg::OP_CHK: begin
                        if (i_stat.opa_zero) begin
                            n_state = S_IDLE;
                            if (r_pc < bi_pkg::PC_RASTER) begin
                                n_degen = 1'b1;
                            end else begin
                                o_cmd.publish   = 1'b1;
                                o_cmd.pub_degen = 1'b1;
                                n_valid         = 1'b1;
                            end
                        end else begin
                            n_pc    = r_pc + 1'b1;
                            n_state = S_READ;
                        end
                    end
                    bi_pkg::OP_JTAIL: begin
                        n_pc    = bi_pkg::PC_TAIL;
                        n_state = S_READ;
                    end
                    bi_pkg::OP_ENDL: begin
                        n_degen = 1'b0;
                        n_state = S_IDLE;
                    end
                    bi_pkg::OP_ENDQ: begin
                        o_cmd.publish = 1'b1;
                        n_valid       = 1'b1;
                        n_state       = S_IDLE;
                    end
                    default: begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_READ;
                    end
                endcase
            end
            S_MULW: begin
                o_cmd.phase = bi_pkg::PH_MULW;
                n_pc        = r_pc + 1'b1;
                n_state     = S_READ;
            end
            S_DIV: begin
                o_cmd.phase = bi_pkg::PH_DIV;
                if (i_stat.div_done) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_degen <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_degen <= n_degen;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== src/bi_dp.sv =====
module bi_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bi_pkg::t_in_item  i_item,
    input  bi_pkg::t_dp_cmd   i_cmd,
    output bi_pkg::t_dp_stat  o_stat,
    output bi_pkg::t_out_item o_result
);

    localparam int W  = bi_pkg::WORD_W;
    localparam int DW = bi_pkg::DIV_W;
    localparam int NE = 2 ** bi_pkg::ADDR_W;

    localparam logic [W-1:0] ONE_Q = W'(1) << bi_pkg::FRAC_W;

    bi_pkg::t_in_item          r_in;
    logic [W-1:0]              r_mem [NE];
    logic [NE-1:0]             r_vld;
    logic [W-1:0]              r_rda, r_rdb;
    logic                      r_rva, r_rvb;
    logic signed [2*W-1:0]     r_prod;
    logic [DW-1:0]             r_nq;
    logic [W-1:0]              r_rem;
    logic [W-1:0]              r_den;
    logic                      r_dneg;
    logic                      r_dzero;
    logic [bi_pkg::CNT_W-1:0]  r_cnt;
    logic [W-1:0]              r_outw [bi_pkg::OUT_CNT];
    bi_pkg::t_out_item         r_res;

    logic [W-1:0]              opa, opb;
    logic [W:0]                sum_ab, dif_ab, one_a;
    logic                      wr_en;
    logic [bi_pkg::ADDR_W-1:0] wr_addr;
    logic [W-1:0]              wr_data;
    logic [W-1:0]              fld;
    logic                      pneg;
    logic [2*W-1:0]            pmag;
    logic [W-1:0]              mul_res, div_res;
    logic [W:0]                trial_src, trial_dif;
    logic                      trial_ge;
    logic [bi_pkg::ADDR_W-1:0] out_off;
    logic                      outside;

    function automatic logic [W-1:0] sat_sum(logic [W:0] s);
        if (s[W] != s[W-1]) begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_mag(logic [DW-1:0] m, logic neg);
        logic [DW-1:0] lim;
        lim = neg ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - 1'b1);
        if (m > lim) begin
            return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    endfunction

    function automatic logic [W-1:0] abs_w(logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign opa = r_rva ? r_rda : '0;
    assign opb = r_rvb ? r_rdb : '0;

    assign sum_ab = {opa[W-1], opa} + {opb[W-1], opb};
    assign dif_ab = {opa[W-1], opa} - {opb[W-1], opb};
    assign one_a  = {1'b0, ONE_Q} - {opa[W-1], opa};

    always_comb begin
        unique case (i_cmd.uop.a[2:0])
            3'd0: fld = r_in.coord_x;
            3'd1: fld = r_in.coord_y;
            3'd2: fld = r_in.coord_z;
            3'd3: fld = r_in.tex_u;
            3'd4: fld = r_in.tex_v;
            3'd5: fld = r_in.norm_x;
            3'd6: fld = r_in.norm_y;
            3'd7: fld = r_in.norm_z;
        endcase
    end

    assign pneg    = r_prod[2*W-1];
    assign pmag    = pneg ? (~r_prod + 1'b1) : r_prod;
    assign mul_res = sat_mag(pmag[2*W-1:bi_pkg::FRAC_W], pneg);
    assign div_res = r_dzero ? '0 : sat_mag(r_nq, r_dneg);

    assign trial_src = {r_rem, r_nq[DW-1]};
    assign trial_dif = trial_src - {1'b0, r_den};
    assign trial_ge  = (trial_src >= {1'b0, r_den});

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_cmd.uop.d;
        wr_data = '0;
        unique case (i_cmd.phase)
            bi_pkg::PH_EXEC: begin
                unique case (i_cmd.uop.op)
                    bi_pkg::OP_LDV: begin
                        wr_en   = 1'b1;
                        wr_addr = {1'b0, r_in.vertex_index, i_cmd.uop.a[2:0]};
                        wr_data = fld;
                    end
                    bi_pkg::OP_LDT: begin
                        wr_en   = 1'b1;
                        wr_data = fld;
                    end
                    bi_pkg::OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = sat_sum(sum_ab);
                    end
                    bi_pkg::OP_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = sat_sum(dif_ab);
                    end
                    bi_pkg::OP_ONESUB: begin
                        wr_en   = 1'b1;
                        wr_data = sat_sum(one_a);
                    end
                    default: wr_en = 1'b0;
                endcase
            end
            bi_pkg::PH_MULW: begin
                wr_en   = 1'b1;
                wr_data = mul_res;
            end
            bi_pkg::PH_DIV: begin
                wr_en   = (r_cnt == '0);
                wr_data = div_res;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign out_off = wr_addr - bi_pkg::ADDR_OUT_BASE;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.phase == bi_pkg::PH_READ) begin
            r_rda <= r_mem[i_cmd.uop.a];
            r_rdb <= r_mem[i_cmd.uop.b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rva <= 1'b0;
            r_rvb <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.phase == bi_pkg::PH_READ) begin
                r_rva <= r_vld[i_cmd.uop.a];
                r_rvb <= r_vld[i_cmd.uop.b];
            end
            if (i_cmd.phase == bi_pkg::PH_EXEC && i_cmd.uop.op == bi_pkg::OP_DIV) begin
                r_cnt <= bi_pkg::CNT_W'(DW);
            end else if (i_cmd.phase == bi_pkg::PH_DIV && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_item;
        end
        if (i_cmd.phase == bi_pkg::PH_EXEC && i_cmd.uop.op == bi_pkg::OP_MUL) begin
            r_prod <= $signed(opa) * $signed(opb);
        end
        if (i_cmd.phase == bi_pkg::PH_EXEC && i_cmd.uop.op == bi_pkg::OP_DIV) begin
            r_nq    <= {abs_w(opa), {bi_pkg::FRAC_W{1'b0}}};
            r_den   <= abs_w(opb);
            r_rem   <= '0;
            r_dneg  <= opa[W-1] ^ opb[W-1];
            r_dzero <= (opb == '0);
        end else if (i_cmd.phase == bi_pkg::PH_DIV && r_cnt != '0) begin
            r_rem <= trial_ge ? trial_dif[W-1:0] : trial_src[W-1:0];
            r_nq  <= {r_nq[DW-2:0], trial_ge};
        end
        if (wr_en && wr_addr >= bi_pkg::ADDR_OUT_BASE && wr_addr <= bi_pkg::ADDR_OUT_LAST) begin
            r_outw[out_off[bi_pkg::OUT_IDX_W-1:0]] <= wr_data;
        end
    end

    assign outside = r_outw[0][W-1] | r_outw[1][W-1] | r_outw[2][W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            if (i_cmd.pub_degen) begin
                r_res <= {{(3*W){1'b0}}, bi_pkg::ST_DEGEN, {(8*W){1'b0}}};
            end else begin
                r_res.weight_first  <= r_outw[0];
                r_res.weight_second <= r_outw[1];
                r_res.weight_third  <= r_outw[2];
                r_res.status        <= outside ? bi_pkg::ST_OUTSIDE : bi_pkg::ST_INSIDE;
                r_res.out_pos_x     <= r_outw[3];
                r_res.out_pos_y     <= r_outw[4];
                r_res.out_pos_z     <= r_outw[5];
                r_res.out_tex_u     <= r_outw[6];
                r_res.out_tex_v     <= r_outw[7];
                r_res.out_norm_x    <= r_outw[8];
                r_res.out_norm_y    <= r_outw[9];
                r_res.out_norm_z    <= r_outw[10];
            end
        end
    end

    assign o_stat.opa_zero = (opa == '0);
    assign o_stat.div_done = (r_cnt == '0);
    assign o_result        = r_res;

endmodule

// ===== src/barycentric_interpolator_top.sv =====
// Barycentric interpolator for one stored triangle.
// Command channel: drive i_item and raise start; the beat is taken on a rising
// edge where start is high and busy is low. Commands: load vertex (0..2),
// raster query (2D point) and spatial query (3D point).
// Result channel: each query gives one beat, o_valid high for exactly one
// cycle with o_result (three weights, status, eight blended attributes).
// Loads and unused command codes give no beat. The receiver cannot stall;
// a result is shown for its single cycle and must be taken then.
// Datapath: a microcoded sequencer drives one shared 32x32 multiplier, saturating
// add/subtract logic and a 48-step restoring divider (one quotient bit per
// cycle) through a 64-word scratch memory. Each micro-op reads its operands,
// then executes; a multiply adds a write-back step, and a divide waits in the
// divider until its quotient is written. Busy stays high while a program runs.
// A raster query against a degenerate triangle answers the cycle after accept.
// The next command may be accepted in the same cycle its predecessor's result
// is shown.
// Reset: vertices read as zero and the triangle is degenerate until loaded.
module barycentric_interpolator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bi_pkg::t_in_item  i_item,
    output logic              busy,
    output logic              o_valid,
    output bi_pkg::t_out_item o_result
);

    bi_pkg::t_dp_cmd  cmd;
    bi_pkg::t_dp_stat stat;

    bi_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_item.command),
        .i_vertex_index (i_item.vertex_index),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_valid        (o_valid)
    );

    bi_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule
